>>> sv/sm83_peu_pkg.sv
// Shared types, opcode names, flag masks and helpers for the SM83 partial execute unit.
// No dependencies; imported by the top level and the checker.
`default_nettype none

package sm83_peu_pkg;

  // Tick counter width (16 to 64)
  localparam int TICK_W     = 32;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  localparam logic [7:0]  FL_Z      = 8'h80;
  localparam logic [7:0]  FL_N      = 8'h40;
  localparam logic [7:0]  FL_H      = 8'h20;
  localparam logic [7:0]  FL_C      = 8'h10;
  localparam logic [7:0]  FL_KEEP_C = 8'h1F;
  localparam logic [7:0]  FL_LOW    = 8'h0F;
  localparam logic [7:0]  HIGH_PAGE = 8'hFF;

  localparam logic [15:0] RST_AF = 16'h01B0;
  localparam logic [15:0] RST_BC = 16'h0013;
  localparam logic [15:0] RST_DE = 16'h00D8;
  localparam logic [15:0] RST_HL = 16'h014D;
  localparam logic [15:0] RST_SP = 16'hFFFE;
  localparam logic [15:0] RST_PC = 16'h0100;

  localparam logic [7:0] OP_NOP      = 8'h00;
  localparam logic [7:0] OP_LD_BC_NN = 8'h01;
  localparam logic [7:0] OP_DEC_B    = 8'h05;
  localparam logic [7:0] OP_LD_B_N   = 8'h06;
  localparam logic [7:0] OP_DEC_BC   = 8'h0B;
  localparam logic [7:0] OP_INC_C    = 8'h0C;
  localparam logic [7:0] OP_DEC_C    = 8'h0D;
  localparam logic [7:0] OP_LD_C_N   = 8'h0E;
  localparam logic [7:0] OP_DEC_DE   = 8'h1B;
  localparam logic [7:0] OP_JR_NZ    = 8'h20;
  localparam logic [7:0] OP_LD_HL_NN = 8'h21;
  localparam logic [7:0] OP_JR_Z     = 8'h28;
  localparam logic [7:0] OP_LDI_A_HL = 8'h2A;
  localparam logic [7:0] OP_LD_SP_NN = 8'h31;
  localparam logic [7:0] OP_LDD_HL_A = 8'h32;
  localparam logic [7:0] OP_LD_HL_N  = 8'h36;
  localparam logic [7:0] OP_JR_C     = 8'h38;
  localparam logic [7:0] OP_INC_A    = 8'h3C;
  localparam logic [7:0] OP_LD_A_N   = 8'h3E;
  localparam logic [7:0] OP_LD_B_E   = 8'h43;
  localparam logic [7:0] OP_LD_A_B   = 8'h78;
  localparam logic [7:0] OP_AND_A    = 8'hA7;
  localparam logic [7:0] OP_XOR_A    = 8'hAF;
  localparam logic [7:0] OP_OR_C     = 8'hB1;
  localparam logic [7:0] OP_RET_NZ   = 8'hC0;
  localparam logic [7:0] OP_JP_NN    = 8'hC3;
  localparam logic [7:0] OP_PUSH_BC  = 8'hC5;
  localparam logic [7:0] OP_RET      = 8'hC9;
  localparam logic [7:0] OP_CALL_NN  = 8'hCD;
  localparam logic [7:0] OP_PUSH_DE  = 8'hD5;
  localparam logic [7:0] OP_RETI     = 8'hD9;
  localparam logic [7:0] OP_LDH_N_A  = 8'hE0;
  localparam logic [7:0] OP_LDH_C_A  = 8'hE2;
  localparam logic [7:0] OP_PUSH_HL  = 8'hE5;
  localparam logic [7:0] OP_LD_NN_A  = 8'hEA;
  localparam logic [7:0] OP_LDH_A_N  = 8'hF0;
  localparam logic [7:0] OP_DI       = 8'hF3;
  localparam logic [7:0] OP_PUSH_AF  = 8'hF5;
  localparam logic [7:0] OP_EI       = 8'hFB;
  localparam logic [7:0] OP_CP_N     = 8'hFE;

  typedef enum logic [2:0] {
    EV_DONE    = 3'd0,
    EV_RD_BYTE = 3'd1,
    EV_RD_WORD = 3'd2,
    EV_WR_BYTE = 3'd3,
    EV_WR_WORD = 3'd4,
    EV_UNIMP   = 3'd5
  } ev_t;

  typedef enum logic [1:0] {
    PEND_NONE = 2'd0,
    PEND_PC   = 2'd1,
    PEND_A    = 2'd2,
    PEND_RETI = 2'd3
  } pend_t;

  typedef struct packed {
    logic        ok;
    logic [1:0]  len;
  } oplen_t;

  // Visible state carried with every result
  typedef struct packed {
    logic [15:0] pc;
    logic [15:0] sp;
    logic [15:0] af;
    logic [15:0] bc;
    logic [15:0] de;
    logic [15:0] hl;
    logic [31:0] cyc;
    logic        ime;
  } arch_t;

  // One queue entry: a step's first result, plus an optional trailing done result
  typedef struct packed {
    ev_t         ev;
    logic [15:0] addr;
    logic [15:0] wdata;
    logic        two;
    arch_t       st;
  } ent_t;

  function automatic oplen_t op_len(input logic [7:0] op);
    oplen_t r;
    r = '{ok: 1'b1, len: 2'd0};
    case (op) inside
      OP_NOP, OP_DEC_B, OP_DEC_BC, OP_INC_C, OP_DEC_C, OP_DEC_DE, OP_LDI_A_HL,
      OP_LDD_HL_A, OP_INC_A, OP_LD_B_E, OP_LD_A_B, OP_AND_A, OP_XOR_A, OP_OR_C,
      OP_RET_NZ, OP_PUSH_BC, OP_RET, OP_PUSH_DE, OP_RETI, OP_LDH_C_A, OP_PUSH_HL,
      OP_DI, OP_PUSH_AF, OP_EI:
        r.len = 2'd0;
      OP_LD_B_N, OP_LD_C_N, OP_JR_NZ, OP_JR_Z, OP_LD_HL_N, OP_JR_C, OP_LD_A_N,
      OP_LDH_N_A, OP_LDH_A_N, OP_CP_N:
        r.len = 2'd1;
      OP_LD_BC_NN, OP_LD_HL_NN, OP_LD_SP_NN, OP_JP_NN, OP_CALL_NN, OP_LD_NN_A:
        r.len = 2'd2;
      default:
        r.ok = 1'b0;
    endcase
    return r;
  endfunction

  // Flags after an 8-bit increment; carry and low nibble kept
  function automatic logic [7:0] inc_flags(input logic [7:0] v, input logic [7:0] f);
    logic [7:0] r;
    logic [7:0] nf;
    r  = v + 8'd1;
    nf = f & FL_KEEP_C;
    if (v[3:0] == 4'hF) nf = nf | FL_H;
    if (r == 8'd0)      nf = nf | FL_Z;
    return nf;
  endfunction

  function automatic logic [7:0] dec_flags(input logic [7:0] v, input logic [7:0] f);
    logic [7:0] r;
    logic [7:0] nf;
    r  = v - 8'd1;
    nf = (f & FL_KEEP_C) | FL_N;
    if (v[3:0] == 4'h0) nf = nf | FL_H;
    if (r == 8'd0)      nf = nf | FL_Z;
    return nf;
  endfunction

endpackage

`default_nettype wire

>>> sv/sm83_partial_execute_unit.sv
// Top level of the SM83 partial execute unit: input register, execute logic,
// architectural registers and result queue. Depends on sm83_peu_pkg.
`default_nettype none

// Channel   Direction  Handshake             Payload
// in_       in         in_valid / in_stall   kind, opcode, operand, read_data
// out_      out        out_valid / out_stall event_res, address, write_data, last,
//                                            pc/sp/af/bc/de/hl, cycle_total, ime
//
// An item transfers into the input register, executes from there against the
// architectural registers once the queue has room, and any result it gives lands in
// a four-entry result queue, from which out_ is driven.
// One item per cycle is accepted while the queue is not full;
// the queue drains one result per cycle while out_stall is low, and a write step
// gives two results, so a run of writes fills it. The input stalls only when it is full.
// Synchronous active-low reset loads the power-on register values and empties
// the queue; no clearing pass is needed.

module sm83_partial_execute_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_kind,
  input  logic [7:0]  in_opcode,
  input  logic [15:0] in_operand,
  input  logic [15:0] in_read_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_event_res,
  output logic [15:0] out_address,
  output logic [15:0] out_write_data,
  output logic        out_last,
  output logic [15:0] out_pc_out,
  output logic [15:0] out_sp_out,
  output logic [15:0] out_af_out,
  output logic [15:0] out_bc_out,
  output logic [15:0] out_de_out,
  output logic [15:0] out_hl_out,
  output logic [31:0] out_cycle_total,
  output logic        out_ime_out
);

  import sm83_peu_pkg::*;

  // Input register
  logic        s1_vld_r, s1_vld_nxt;
  logic        s1_kind_r;
  logic [7:0]  s1_op_r;
  logic [15:0] s1_opd_r;
  logic [15:0] s1_rd_r;

  // Architectural state
  logic [15:0] af_r, bc_r, de_r, hl_r, sp_r, pc_r;
  logic [15:0] af_nxt, bc_nxt, de_nxt, hl_nxt, sp_nxt, pc_nxt;
  logic        ime_r, ime_nxt;
  logic        stop_r, stop_nxt;
  pend_t       pend_r, pend_nxt;
  logic [TICK_W-1:0] tick_r, tick_nxt;

  // Result queue
  ent_t                fifo_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [FIFO_CW-1:0]  cnt_r, cnt_nxt;
  logic                half_r;

  logic        in_xfer, out_xfer;
  logic        do_exec, push_c, pop_c;
  ent_t        ent_c, head_c;
  ev_t         ev_c;
  logic [15:0] addr_c, wdata_c;
  logic        two_c;
  logic [4:0]  tk_c;
  oplen_t      ol_c;
  logic [15:0] pc_seq_c, rel_c;
  logic [7:0]  imm_c, a_c, f_c, or_c;

  assign do_exec  = s1_vld_r && (cnt_r != FIFO_CW'(FIFO_DEPTH));
  assign in_stall = s1_vld_r && !do_exec;
  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid && !out_stall;

  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (in_xfer) begin
      s1_vld_nxt = 1'b1;
    end else if (do_exec) begin
      s1_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
    end
    if (in_xfer) begin
      s1_kind_r <= in_kind;
      s1_op_r   <= in_opcode;
      s1_opd_r  <= in_operand;
      s1_rd_r   <= in_read_data;
    end
  end

  // Execute
  assign imm_c    = s1_opd_r[7:0];
  assign a_c      = af_r[15:8];
  assign f_c      = af_r[7:0];
  assign or_c     = a_c | bc_r[7:0];
  assign ol_c     = op_len(s1_op_r);
  assign pc_seq_c = pc_r + 16'd1 + 16'(ol_c.len);
  assign rel_c    = pc_seq_c + {{8{imm_c[7]}}, imm_c};

  always_comb begin
    af_nxt   = af_r;
    bc_nxt   = bc_r;
    de_nxt   = de_r;
    hl_nxt   = hl_r;
    sp_nxt   = sp_r;
    pc_nxt   = pc_r;
    ime_nxt  = ime_r;
    stop_nxt = stop_r;
    pend_nxt = pend_r;
    ev_c     = EV_DONE;
    addr_c   = 16'd0;
    wdata_c  = 16'd0;
    two_c    = 1'b0;
    push_c   = 1'b0;
    tk_c     = 5'd0;

    if (stop_r) begin
      push_c = 1'b1;
      ev_c   = EV_UNIMP;
    end else if (s1_kind_r) begin
      // read data for the outstanding request; dropped when none is pending
      if (pend_r != PEND_NONE) begin
        push_c = 1'b1;
        if (pend_r == PEND_A) begin
          af_nxt = {s1_rd_r[7:0], f_c};
        end else begin
          pc_nxt = s1_rd_r;
        end
        if (pend_r == PEND_RETI) begin
          ime_nxt = 1'b1;
        end
        pend_nxt = PEND_NONE;
      end
    end else if (pend_r == PEND_NONE) begin
      push_c = 1'b1;
      if (!ol_c.ok) begin
        stop_nxt = 1'b1;
        ev_c     = EV_UNIMP;
      end else begin
        pc_nxt = pc_seq_c;
        case (s1_op_r)
          OP_NOP:      tk_c = 5'd2;
          OP_LD_BC_NN: begin bc_nxt = s1_opd_r; tk_c = 5'd6; end
          OP_DEC_B: begin
            bc_nxt = {bc_r[15:8] - 8'd1, bc_r[7:0]};
            af_nxt = {a_c, dec_flags(bc_r[15:8], f_c)};
            tk_c   = 5'd2;
          end
          OP_LD_B_N:   begin bc_nxt = {imm_c, bc_r[7:0]}; tk_c = 5'd4; end
          OP_DEC_BC:   begin bc_nxt = bc_r - 16'd1; tk_c = 5'd4; end
          OP_INC_C: begin
            bc_nxt = {bc_r[15:8], bc_r[7:0] + 8'd1};
            af_nxt = {a_c, inc_flags(bc_r[7:0], f_c)};
            tk_c   = 5'd2;
          end
          OP_DEC_C: begin
            bc_nxt = {bc_r[15:8], bc_r[7:0] - 8'd1};
            af_nxt = {a_c, dec_flags(bc_r[7:0], f_c)};
            tk_c   = 5'd2;
          end
          OP_LD_C_N:   begin bc_nxt = {bc_r[15:8], imm_c}; tk_c = 5'd4; end
          OP_DEC_DE:   begin de_nxt = de_r - 16'd1; tk_c = 5'd4; end
          OP_JR_NZ: begin
            if ((f_c & FL_Z) != 8'd0) begin
              tk_c = 5'd8;
            end else begin
              pc_nxt = rel_c;
              tk_c   = 5'd12;
            end
          end
          OP_LD_HL_NN: begin hl_nxt = s1_opd_r; tk_c = 5'd6; end
          OP_JR_Z: begin
            if ((f_c & FL_Z) != 8'd0) begin
              pc_nxt = rel_c;
              tk_c   = 5'd12;
            end else begin
              tk_c = 5'd8;
            end
          end
          OP_LDI_A_HL: begin
            ev_c     = EV_RD_BYTE;
            addr_c   = hl_r;
            pend_nxt = PEND_A;
            hl_nxt   = hl_r + 16'd1;
            tk_c     = 5'd4;
          end
          OP_LD_SP_NN: begin sp_nxt = s1_opd_r; tk_c = 5'd6; end
          OP_LDD_HL_A: begin
            ev_c    = EV_WR_BYTE;
            addr_c  = hl_r;
            wdata_c = {8'd0, a_c};
            two_c   = 1'b1;
            hl_nxt  = hl_r - 16'd1;
            tk_c    = 5'd4;
          end
          OP_LD_HL_N: begin
            ev_c    = EV_WR_BYTE;
            addr_c  = hl_r;
            wdata_c = {8'd0, imm_c};
            two_c   = 1'b1;
            tk_c    = 5'd6;
          end
          OP_JR_C: begin
            if ((f_c & FL_C) != 8'd0) begin
              pc_nxt = rel_c;
              tk_c   = 5'd12;
            end else begin
              tk_c = 5'd8;
            end
          end
          OP_INC_A: begin
            af_nxt = {a_c + 8'd1, inc_flags(a_c, f_c)};
            tk_c   = 5'd2;
          end
          OP_LD_A_N:   begin af_nxt = {imm_c, f_c}; tk_c = 5'd4; end
          OP_LD_B_E:   begin bc_nxt = {de_r[7:0], bc_r[7:0]}; tk_c = 5'd2; end
          OP_LD_A_B:   begin af_nxt = {bc_r[15:8], f_c}; tk_c = 5'd2; end
          OP_AND_A: begin
            af_nxt = {a_c, (f_c & FL_LOW) | FL_H | ((a_c == 8'd0) ? FL_Z : 8'd0)};
            tk_c   = 5'd2;
          end
          OP_XOR_A: begin
            af_nxt = {8'd0, (f_c & FL_LOW) | FL_Z};
            tk_c   = 5'd2;
          end
          OP_OR_C: begin
            af_nxt = {or_c, (f_c & FL_LOW) | ((or_c == 8'd0) ? FL_Z : 8'd0)};
            tk_c   = 5'd2;
          end
          OP_RET_NZ: begin
            if ((f_c & FL_Z) != 8'd0) begin
              tk_c = 5'd8;
            end else begin
              ev_c     = EV_RD_WORD;
              addr_c   = sp_r;
              pend_nxt = PEND_PC;
              sp_nxt   = sp_r + 16'd2;
              tk_c     = 5'd20;
            end
          end
          OP_JP_NN:    begin pc_nxt = s1_opd_r; tk_c = 5'd6; end
          OP_RET: begin
            ev_c     = EV_RD_WORD;
            addr_c   = sp_r;
            pend_nxt = PEND_PC;
            sp_nxt   = sp_r + 16'd2;
            tk_c     = 5'd2;
          end
          OP_RETI: begin
            ev_c     = EV_RD_WORD;
            addr_c   = sp_r;
            pend_nxt = PEND_RETI;
            sp_nxt   = sp_r + 16'd2;
            tk_c     = 5'd8;
          end
          OP_PUSH_BC, OP_PUSH_DE, OP_PUSH_HL, OP_PUSH_AF: begin
            sp_nxt = sp_r - 16'd2;
            ev_c   = EV_WR_WORD;
            addr_c = sp_r - 16'd2;
            two_c  = 1'b1;
            tk_c   = 5'd8;
            case (s1_op_r)
              OP_PUSH_BC: wdata_c = bc_r;
              OP_PUSH_DE: wdata_c = de_r;
              OP_PUSH_HL: wdata_c = hl_r;
              default:    wdata_c = af_r;
            endcase
          end
          OP_CALL_NN: begin
            sp_nxt  = sp_r - 16'd2;
            ev_c    = EV_WR_WORD;
            addr_c  = sp_r - 16'd2;
            wdata_c = pc_seq_c;
            two_c   = 1'b1;
            pc_nxt  = s1_opd_r;
            tk_c    = 5'd6;
          end
          OP_LDH_N_A: begin
            ev_c    = EV_WR_BYTE;
            addr_c  = {HIGH_PAGE, imm_c};
            wdata_c = {8'd0, a_c};
            two_c   = 1'b1;
            tk_c    = 5'd6;
          end
          OP_LDH_C_A: begin
            ev_c    = EV_WR_BYTE;
            addr_c  = {HIGH_PAGE, bc_r[7:0]};
            wdata_c = {8'd0, a_c};
            two_c   = 1'b1;
            tk_c    = 5'd4;
          end
          OP_LD_NN_A: begin
            ev_c    = EV_WR_BYTE;
            addr_c  = s1_opd_r;
            wdata_c = {8'd0, a_c};
            two_c   = 1'b1;
            tk_c    = 5'd8;
          end
          OP_LDH_A_N: begin
            ev_c     = EV_RD_BYTE;
            addr_c   = {HIGH_PAGE, imm_c};
            pend_nxt = PEND_A;
            tk_c     = 5'd6;
          end
          OP_DI:       begin ime_nxt = 1'b0; tk_c = 5'd2; end
          OP_EI:       begin ime_nxt = 1'b1; tk_c = 5'd2; end
          OP_CP_N: begin
            af_nxt = {a_c, (f_c & FL_LOW) | FL_N
                           | ((a_c == imm_c) ? FL_Z : 8'd0)
                           | ((imm_c > a_c) ? FL_C : 8'd0)
                           | ((imm_c[3:0] > a_c[3:0]) ? FL_H : 8'd0)};
            tk_c   = 5'd4;
          end
          default: tk_c = 5'd0;
        endcase
      end
    end
    // executed instruction items set tk_c; everything else adds nothing
    tick_nxt = tick_r + TICK_W'(tk_c);
  end

  always_comb begin
    ent_c.ev     = ev_c;
    ent_c.addr   = addr_c;
    ent_c.wdata  = wdata_c;
    ent_c.two    = two_c;
    ent_c.st.pc  = pc_nxt;
    ent_c.st.sp  = sp_nxt;
    ent_c.st.af  = af_nxt;
    ent_c.st.bc  = bc_nxt;
    ent_c.st.de  = de_nxt;
    ent_c.st.hl  = hl_nxt;
    ent_c.st.cyc = 32'(tick_nxt);
    ent_c.st.ime = ime_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      af_r   <= RST_AF;
      bc_r   <= RST_BC;
      de_r   <= RST_DE;
      hl_r   <= RST_HL;
      sp_r   <= RST_SP;
      pc_r   <= RST_PC;
      ime_r  <= 1'b1;
      stop_r <= 1'b0;
      pend_r <= PEND_NONE;
      tick_r <= '0;
    end else if (do_exec) begin
      af_r   <= af_nxt;
      bc_r   <= bc_nxt;
      de_r   <= de_nxt;
      hl_r   <= hl_nxt;
      sp_r   <= sp_nxt;
      pc_r   <= pc_nxt;
      ime_r  <= ime_nxt;
      stop_r <= stop_nxt;
      pend_r <= pend_nxt;
      tick_r <= tick_nxt;
    end
  end

  // Result queue; a write step occupies one entry and leaves as two transfers
  assign head_c = fifo_r[rd_ptr_r];
  assign pop_c  = out_xfer && (half_r || !head_c.two);

  always_comb begin
    cnt_nxt = cnt_r;
    if ((do_exec && push_c) && !pop_c) begin
      cnt_nxt = cnt_r + FIFO_CW'(1);
    end else if (!(do_exec && push_c) && pop_c) begin
      cnt_nxt = cnt_r - FIFO_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
      half_r   <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_exec && push_c) begin
        wr_ptr_r <= wr_ptr_r + FIFO_AW'(1);
      end
      if (pop_c) begin
        rd_ptr_r <= rd_ptr_r + FIFO_AW'(1);
      end
      if (out_xfer) begin
        half_r <= !half_r && head_c.two;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_exec && push_c) begin
      fifo_r[wr_ptr_r] <= ent_c;
    end
  end

  // Second half of a write step is the trailing done result
  assign out_valid       = (cnt_r != '0);
  assign out_event_res   = half_r ? EV_DONE : head_c.ev;
  assign out_address     = half_r ? 16'd0 : head_c.addr;
  assign out_write_data  = half_r ? 16'd0 : head_c.wdata;
  assign out_last        = half_r || !head_c.two;
  assign out_pc_out      = head_c.st.pc;
  assign out_sp_out      = head_c.st.sp;
  assign out_af_out      = head_c.st.af;
  assign out_bc_out      = head_c.st.bc;
  assign out_de_out      = head_c.st.de;
  assign out_hl_out      = head_c.st.hl;
  assign out_cycle_total = head_c.st.cyc;
  assign out_ime_out     = head_c.st.ime;

endmodule

`default_nettype wire

>>> sv/sm83_peu_chk.sv
// Port-level checker for the SM83 partial execute unit, with its bind statement.
// Depends on sm83_peu_pkg and the top level's port names.
`default_nettype none

module sm83_peu_chk (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [2:0]  out_event_res,
  input  logic [15:0] out_address,
  input  logic [15:0] out_write_data,
  input  logic        out_last
);

  import sm83_peu_pkg::*;

  logic out_xfer;
  assign out_xfer = out_valid && !out_stall;

  // stopped and unimplemented results always stand alone
  a_unimp_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_res == EV_UNIMP) |-> out_last)
    else $error("unimplemented result not marked last");

  // only writes are followed by a second result
  a_nonlast_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> (out_event_res == EV_WR_BYTE) ||
                               (out_event_res == EV_WR_WORD))
    else $error("non-final result that is not a write");

  // the done result of a write step follows straight after the write transfer
  a_write_tail: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer && !out_last |=> out_valid && out_last && (out_event_res == EV_DONE))
    else $error("write not followed by its done result");

  a_done_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_res == EV_DONE) |-> (out_address == 16'd0) &&
                                                (out_write_data == 16'd0))
    else $error("done result carries address or data");

  a_byte_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_res == EV_WR_BYTE) |-> (out_write_data[15:8] == 8'd0))
    else $error("byte write with non-zero high byte");

endmodule

bind sm83_partial_execute_unit sm83_peu_chk u_sm83_peu_chk (.*);

`default_nettype wire
